// ===== rtl/sample_playback_voice_assert.svh =====
`ifndef SAMPLE_PLAYBACK_VOICE_ASSERT_SVH
`define SAMPLE_PLAYBACK_VOICE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/svp_pkg.sv =====
package svp_pkg;

  localparam int STORE_DEPTH   = 65536;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 12;
  localparam int VOL_SHIFT     = 12;
  localparam int COUNT_W       = 17;
  localparam int STEP_W        = 21;
  localparam int VOL_W         = 16;
  localparam int FADE_W        = 17;
  localparam int LOOP_W        = 17;
  localparam int CFG_W         = 21;
  localparam int REG_IDX_W     = 3;
  localparam int POS_W         = ADDR_W + FRACTION_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int LEVEL_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_VOLUME  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_VOLUME = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FADE_IN      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FADE_OUT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_COUNT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE  = 3'd7;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_PULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_START,
    OP_STOP,
    OP_PULL
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [STEP_W-1:0] step;
    logic [VOL_W-1:0]         lvol;
    logic [VOL_W-1:0]         rvol;
    logic [FADE_W-1:0]        fin;
    logic [FADE_W-1:0]        fout;
    logic signed [LOOP_W-1:0] loops;
    logic                     stereo;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
  } front_stat_t;

  typedef struct packed {
    logic playing;
    logic busy;
  } back_stat_t;

endpackage

// ===== rtl/svp_if.sv =====
interface svp_in_if import svp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [ADDR_W-1:0]             sample_address;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, kind, sample_address, left_sample, right_sample,
                  input ready);
  modport sink (input valid, kind, sample_address, left_sample, right_sample,
                output ready);
endinterface

interface svp_out_if import svp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          frame_valid;
  logic                          finished;

  modport source (output valid, left_out, right_out, frame_valid, finished,
                  input ready);
  modport sink (input valid, left_out, right_out, frame_valid, finished,
                output ready);
endinterface

// ===== rtl/svp_front.sv =====
module svp_front import svp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  svp_in_if.sink      in_ch,
  output item_t       item,
  output logic        item_valid,
  input  logic        item_ready,
  output front_stat_t stat
);

  item_t              q_r [QUEUE_DEPTH];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  item_t              cls;
  logic               push, pop;

  always_comb begin
    cls.addr  = in_ch.sample_address;
    cls.left  = in_ch.left_sample;
    cls.right = in_ch.right_sample;
    unique case (in_ch.kind)
      KIND_WRITE: cls.op = OP_WRITE;
      KIND_START: cls.op = OP_START;
      KIND_STOP:  cls.op = OP_STOP;
      default:    cls.op = OP_PULL;
    endcase
  end

  assign in_ch.ready = (level_r != LEVEL_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (level_r != '0);
  assign pop         = item_valid && item_ready;
  assign item        = q_r[rd_ptr_r];
  assign stat.level  = level_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + LEVEL_W'(push) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/svp_div.sv =====
module svp_div import svp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*VOL_W-1:0] num,
  input  logic [FADE_W-1:0]  den,
  output logic               busy,
  output logic [VOL_W-1:0]   quo
);

  localparam int CNT_W = $clog2(VOL_W);

  logic [FADE_W-1:0] rem_r, rem_nxt;
  logic [VOL_W-1:0]  low_r, low_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [FADE_W:0]   trial;
  logic              ge;

  // quotient is known to fit VOL_W bits, so the upper half starts below den
  always_comb begin
    trial    = {rem_r, low_r[VOL_W-1]};
    ge       = (trial >= {1'b0, den});
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = FADE_W'(num[2*VOL_W-1:VOL_W]);
      low_nxt  = num[VOL_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? FADE_W'(trial - {1'b0, den}) : trial[FADE_W-1:0];
      low_nxt = {low_r[VOL_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VOL_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
  end

  assign busy = busy_r;
  assign quo  = low_r;

endmodule

// ===== rtl/svp_back.sv =====
module svp_back import svp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_ready,
  svp_out_if.source  out_ch,
  output back_stat_t stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam int ONE    = 1 << FRACTION_BITS;
  localparam int WGT_W  = FRACTION_BITS + 2;
  localparam int PROD_W = SAMPLE_BITS + WGT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int VPR_W  = SAMPLE_BITS + VOL_W + 1;
  localparam int NPOS_W = POS_W + 3;
  localparam int WORD_W = 2 * SAMPLE_BITS;

  logic [WORD_W-1:0] mem [STORE_DEPTH];
  logic [WORD_W-1:0] rdata0_r, rdata1_r;
  logic [ADDR_W-1:0] raddr0, raddr1;
  logic              mem_we;

  logic [2:0] state_r, state_nxt;
  logic       playing_r, playing_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic signed [LOOP_W-1:0] loops_r, loops_nxt;

  logic [FRACTION_BITS-1:0] frac_r;
  logic [1:0]               fade_r;
  logic [VOL_W-1:0]         factor_r;
  logic signed [PROD_W-1:0] pl0_r, pl1_r, pr0_r, pr1_r;
  logic signed [SAMPLE_BITS-1:0] sl_r, sr_r;
  logic [2*VOL_W-1:0]       numl, numr;
  logic [FADE_W-1:0]        fden;
  logic                     div_start;
  logic                     busy_l, busy_r_div;
  logic [VOL_W-1:0]         ql, qr;
  logic signed [VPR_W-1:0]  vl_r, vr_r;

  logic                           ov_r;
  logic signed [SAMPLE_BITS-1:0]  ol_r, or_r;
  logic                           ofv_r, ofin_r;
  logic                           out_free;

  logic [ADDR_W-1:0]        idx;
  logic [COUNT_W-1:0]       len;
  logic [POS_W-1:0]         len_pos;
  logic [COUNT_W-1:0]       diff;
  logic                     do_out, do_in;
  logic [ADDR_W-1:0]        start_p;
  logic signed [NPOS_W-1:0] npos, wpos;
  logic                     wrap;
  logic signed [LOOP_W-1:0] lnext;
  logic signed [SUM_W-1:0]  suml, sumr;
  logic [VOL_W-1:0]         vol_l, vol_r;

  assign out_free   = !ov_r || out_ch.ready;
  assign item_ready = (state_r == ST_IDLE) && out_free;
  assign idx        = pos_r[POS_W-1:FRACTION_BITS];
  assign len        = cfg.count - COUNT_W'(2);
  assign len_pos    = POS_W'({len, {FRACTION_BITS{1'b0}}});
  assign diff       = cfg.count - COUNT_W'(idx);
  assign do_out     = (cfg.fout != '0) && (COUNT_W'(idx) <= cfg.count) && (diff < cfg.fout);
  assign do_in      = (cfg.fin != '0) && (FADE_W'(idx) < cfg.fin);
  assign start_p    = (COUNT_W'(item.addr) > len) ? len[ADDR_W-1:0] : item.addr;
  assign raddr0     = idx;
  assign raddr1     = idx + 1'b1;
  assign mem_we     = item_ready && item_valid && (item.op == OP_WRITE);

  assign numl      = (2*VOL_W)'(factor_r) * (2*VOL_W)'(cfg.lvol);
  assign numr      = (2*VOL_W)'(factor_r) * (2*VOL_W)'(cfg.rvol);
  assign fden      = (fade_r == 2'd2) ? cfg.fout : cfg.fin;
  assign div_start = (state_r == ST_MUL) && (fade_r != 2'd0);
  assign vol_l     = (fade_r != 2'd0) ? ql : cfg.lvol;
  assign vol_r     = (fade_r != 2'd0) ? qr : cfg.rvol;

  assign suml = SUM_W'(pl0_r) + SUM_W'(pl1_r);
  assign sumr = SUM_W'(pr0_r) + SUM_W'(pr1_r);

  svp_div u_div_l (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numl), .den(fden),
    .busy(busy_l), .quo(ql)
  );

  svp_div u_div_r (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numr), .den(fden),
    .busy(busy_r_div), .quo(qr)
  );

  always_comb begin
    npos  = NPOS_W'($signed({1'b0, pos_r})) + NPOS_W'(cfg.step);
    wrap  = (npos >= $signed(NPOS_W'({1'b0, len_pos}))) || (npos <= 0);
    lnext = loops_r;
    wpos  = npos;
    if (wrap) begin
      wpos = (cfg.step > 0) ? npos - NPOS_W'({1'b0, len_pos})
                            : npos + NPOS_W'({1'b0, len_pos});
      if (loops_r > 0) begin
        lnext = loops_r - 1'b1;
      end
    end
    if (wpos < 0) begin
      wpos = '0;
    end
    if (wpos > $signed(NPOS_W'({1'b0, len_pos}))) begin
      wpos = NPOS_W'({1'b0, len_pos});
    end
  end

  always_comb begin
    state_nxt   = state_r;
    playing_nxt = playing_r;
    pos_nxt     = pos_r;
    loops_nxt   = loops_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid && item_ready) begin
          unique case (item.op)
            OP_START: begin
              pos_nxt     = POS_W'({start_p, {FRACTION_BITS{1'b0}}});
              loops_nxt   = cfg.loops;
              playing_nxt = 1'b1;
            end
            OP_STOP: playing_nxt = 1'b0;
            OP_PULL: begin
              if (playing_r) begin
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (!div_start && !busy_l && !busy_r_div) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          pos_nxt   = wpos[POS_W-1:0];
          loops_nxt = lnext;
          if (wrap && lnext == 0) begin
            playing_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      playing_r <= 1'b0;
      pos_r     <= '0;
      loops_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      playing_r <= playing_nxt;
      pos_r     <= pos_nxt;
      loops_r   <= loops_nxt;
      if (state_r == ST_IDLE && item_valid && item_ready && item.op == OP_PULL
          && !playing_r) begin
        ov_r <= 1'b1;
      end else if (state_r == ST_EMIT && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item.addr] <= {item.right, item.left};
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      frac_r   <= pos_r[FRACTION_BITS-1:0];
      fade_r   <= do_out ? 2'd2 : (do_in ? 2'd1 : 2'd0);
      factor_r <= do_out ? diff[VOL_W-1:0] : idx;
    end
    if (state_r == ST_READ) begin
      pl0_r <= PROD_W'($signed(rdata0_r[SAMPLE_BITS-1:0]))
             * PROD_W'($signed({1'b0, WGT_W'(ONE) - WGT_W'(frac_r)}));
      pl1_r <= PROD_W'($signed(rdata1_r[SAMPLE_BITS-1:0]))
             * PROD_W'($signed({2'b00, frac_r}));
      pr0_r <= PROD_W'($signed(rdata0_r[WORD_W-1:SAMPLE_BITS]))
             * PROD_W'($signed({1'b0, WGT_W'(ONE) - WGT_W'(frac_r)}));
      pr1_r <= PROD_W'($signed(rdata1_r[WORD_W-1:SAMPLE_BITS]))
             * PROD_W'($signed({2'b00, frac_r}));
    end
    if (state_r == ST_MUL) begin
      sl_r <= suml[FRACTION_BITS +: SAMPLE_BITS];
      sr_r <= cfg.stereo ? sumr[FRACTION_BITS +: SAMPLE_BITS]
                         : suml[FRACTION_BITS +: SAMPLE_BITS];
    end
    if (state_r == ST_SCALE) begin
      vl_r <= VPR_W'(sl_r) * VPR_W'($signed({1'b0, vol_l}));
      vr_r <= VPR_W'(sr_r) * VPR_W'($signed({1'b0, vol_r}));
    end
    if (state_r == ST_IDLE && item_valid && item_ready && item.op == OP_PULL
        && !playing_r) begin
      ol_r   <= '0;
      or_r   <= '0;
      ofv_r  <= 1'b0;
      ofin_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      ol_r   <= vl_r[VOL_SHIFT +: SAMPLE_BITS];
      or_r   <= vr_r[VOL_SHIFT +: SAMPLE_BITS];
      ofv_r  <= 1'b1;
      ofin_r <= wrap && (lnext == 0);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.left_out    = ol_r;
  assign out_ch.right_out   = or_r;
  assign out_ch.frame_valid = ofv_r;
  assign out_ch.finished    = ofin_r;
  assign stat.playing       = playing_r;
  assign stat.busy          = (state_r != ST_IDLE);

endmodule

// ===== rtl/sample_playback_voice.sv =====
// One voice of a linearly interpolating stereo sample player. Requests on
// in_ch write the 64K-entry sample store, start playback at a sample
// position, stop it, or pull one frame; only a pull gives a result on
// out_ch. Writes, starts and stops are done in the executing stage.
// A pull while stopped returns an all-zero frame. A pull while playing
// reads both neighbouring samples from the two-port store, does the
// interpolation multiplies and then the sum, runs the two bit-serial fade
// dividers (one quotient bit per cycle) when a fade applies, does the
// volume multiply and loads the output register once the output side is
// free. A two-entry request queue sits in front of the executing stage.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the voice is idle, as
// the voice itself does not enforce this.
`include "sample_playback_voice_assert.svh"

module sample_playback_voice import svp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  svp_in_if.sink               in_ch,
  svp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [COUNT_W-1:0]       count_r;
  logic signed [STEP_W-1:0] step_r;
  logic [VOL_W-1:0]         lvol_r, rvol_r;
  logic [FADE_W-1:0]        fin_r, fout_r;
  logic signed [LOOP_W-1:0] loops_r;
  logic                     stereo_r;

  cfg_t        cfg;
  item_t       item;
  logic        item_valid, item_ready;
  front_stat_t fstat;
  back_stat_t  bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= COUNT_W'(STORE_DEPTH);
      step_r   <= STEP_W'(1 << FRACTION_BITS);
      lvol_r   <= VOL_W'(1 << VOL_SHIFT);
      rvol_r   <= VOL_W'(1 << VOL_SHIFT);
      fin_r    <= '0;
      fout_r   <= '0;
      loops_r  <= '0;
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
        REG_STEP:         step_r   <= cfg_wdata[STEP_W-1:0];
        REG_LEFT_VOLUME:  lvol_r   <= cfg_wdata[VOL_W-1:0];
        REG_RIGHT_VOLUME: rvol_r   <= cfg_wdata[VOL_W-1:0];
        REG_FADE_IN:      fin_r    <= cfg_wdata[FADE_W-1:0];
        REG_FADE_OUT:     fout_r   <= cfg_wdata[FADE_W-1:0];
        REG_LOOP_COUNT:   loops_r  <= cfg_wdata[LOOP_W-1:0];
        REG_STEREO_MODE:  stereo_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.count  = count_r;
    if (count_r < COUNT_W'(3)) begin
      cfg.count = COUNT_W'(3);
    end else if (count_r > COUNT_W'(STORE_DEPTH)) begin
      cfg.count = COUNT_W'(STORE_DEPTH);
    end
    cfg.step   = (step_r == '0) ? STEP_W'(1) : step_r;
    cfg.lvol   = lvol_r;
    cfg.rvol   = rvol_r;
    cfg.fin    = fin_r;
    cfg.fout   = fout_r;
    cfg.loops  = loops_r;
    cfg.stereo = stereo_r;
  end

  svp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .item(item), .item_valid(item_valid), .item_ready(item_ready), .stat(fstat)
  );

  svp_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .item(item), .item_valid(item_valid), .item_ready(item_ready),
    .out_ch(out_ch), .stat(bstat)
  );

  `SVP_ASSERT_IMP(a_idle_frame_zero, out_ch.valid && !out_ch.frame_valid, out_ch.left_out == '0 && out_ch.right_out == '0 && !out_ch.finished, "stopped frame not zero")
  `SVP_ASSERT_IMP(a_finish_valid, out_ch.valid && out_ch.finished, out_ch.frame_valid, "finished without frame")
  `SVP_ASSERT_IMP(a_queue_bound, 1'b1, fstat.level <= LEVEL_W'(QUEUE_DEPTH), "queue overfilled")
  `SVP_ASSERT_IMP(a_finish_stops, out_ch.valid && out_ch.finished, !bstat.playing && !bstat.busy, "still playing after finish")

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import svp_pkg::*;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               frame_valid;
    logic               finished;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  svp_in_if in_if ();
  svp_out_if out_if ();

  sample_playback_voice dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the voice
  logic signed [15:0] store_l [STORE_DEPTH];
  logic signed [15:0] store_r [STORE_DEPTH];
  logic [CFG_W-1:0] reg_shadow [8];
  longint voice_pos;
  longint voice_loops;
  bit voice_on;

  frame_t pending_frames[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  function automatic longint read_store(bit chan, longint idx);
    if (idx < 0 || idx >= STORE_DEPTH) return 0;
    return chan ? longint'(store_r[idx]) : longint'(store_l[idx]);
  endfunction

  function automatic longint faded_gain(longint vol, longint idx, longint cnt);
    longint fin, fout;
    fin = reg_shadow[REG_FADE_IN][16:0];
    fout = reg_shadow[REG_FADE_OUT][16:0];
    if (fout > 0 && idx <= cnt && cnt - idx < fout) return (cnt - idx) * vol / fout;
    if (fin > 0 && idx < fin) return idx * vol / fin;
    return vol;
  endfunction

  function automatic longint interpolate(bit chan, longint idx, longint f);
    return (read_store(chan, idx) * (4096 - f) + read_store(chan, idx + 1) * f) >>> 12;
  endfunction

  function automatic void predict_request(logic [1:0] kind, logic [15:0] addr,
                                          logic [15:0] l, logic [15:0] r);
    longint cnt, len, pos, idx, f, stp, s0, s1, lv, rv, prod;
    frame_t fr;
    cnt = reg_shadow[REG_SAMPLE_COUNT][16:0];
    if (cnt < 3) cnt = 3;
    if (cnt > STORE_DEPTH) cnt = STORE_DEPTH;
    len = cnt - 2;
    fr = '0;
    case (kind)
      KIND_WRITE: begin
        store_l[addr] = l;
        store_r[addr] = r;
      end
      KIND_START: begin
        pos = addr;
        if (pos > len) pos = len;
        voice_pos = pos << 12;
        voice_loops = longint'($signed(reg_shadow[REG_LOOP_COUNT][16:0]));
        voice_on = 1'b1;
      end
      KIND_STOP: voice_on = 1'b0;
      default: begin
        if (voice_on) begin
          pos = voice_pos < 0 ? 0 : voice_pos;
          idx = pos >>> 12;
          f = pos & 4095;
          stp = longint'($signed(reg_shadow[REG_STEP][20:0]));
          if (stp == 0) stp = 1;
          lv = faded_gain(reg_shadow[REG_LEFT_VOLUME][15:0], idx, cnt);
          rv = faded_gain(reg_shadow[REG_RIGHT_VOLUME][15:0], idx, cnt);
          s0 = interpolate(1'b0, idx, f);
          s1 = reg_shadow[REG_STEREO_MODE][0] ? interpolate(1'b1, idx, f) : s0;
          prod = (s0 * lv) >>> 12;
          fr.left_out = prod[15:0];
          prod = (s1 * rv) >>> 12;
          fr.right_out = prod[15:0];
          fr.frame_valid = 1'b1;
          pos += stp;
          if ((pos >>> 12) >= len || pos <= 0) begin
            pos += stp > 0 ? -(len << 12) : (len << 12);
            if (voice_loops > 0) voice_loops--;
            if (voice_loops == 0) begin
              voice_on = 1'b0;
              fr.finished = 1'b1;
            end
          end
          if (pos < 0) pos = 0;
          if (pos > (len << 12)) pos = len << 12;
          voice_pos = pos;
        end
        pending_frames.push_back(fr);
      end
    endcase
  endfunction

  task automatic send_request(logic [1:0] kind, logic [15:0] addr,
                              logic [15:0] l = '0, logic [15:0] r = '0);
    if (!no_idle && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.sample_address <= addr;
    in_if.left_sample <= l;
    in_if.right_sample <= r;
    do @(posedge clk); while (!in_if.ready);
    predict_request(kind, addr, l, r);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    reg_shadow[idx] = value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_voice(int cnt, int stp, int lv, int rv, int fin, int fout,
                           int loops, int stereo);
    write_reg(REG_SAMPLE_COUNT, cnt);
    write_reg(REG_STEP, stp);
    write_reg(REG_LEFT_VOLUME, lv);
    write_reg(REG_RIGHT_VOLUME, rv);
    write_reg(REG_FADE_IN, fin);
    write_reg(REG_FADE_OUT, fout);
    write_reg(REG_LOOP_COUNT, loops);
    write_reg(REG_STEREO_MODE, stereo);
  endtask

  // result side: random back-pressure plus a long hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_n && (no_idle || $urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    frame_t exp_fr;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_frames.size() == 0) begin
        $error("frame with no request waiting");
        errors++;
      end else begin
        exp_fr = pending_frames.pop_front();
        if (out_if.left_out !== exp_fr.left_out) begin
          $error("left_out expected %0d got %0d", exp_fr.left_out, out_if.left_out);
          errors++;
        end
        if (out_if.right_out !== exp_fr.right_out) begin
          $error("right_out expected %0d got %0d", exp_fr.right_out, out_if.right_out);
          errors++;
        end
        if (out_if.frame_valid !== exp_fr.frame_valid) begin
          $error("frame_valid expected %0d got %0d", exp_fr.frame_valid,
                 out_if.frame_valid);
          errors++;
        end
        if (out_if.finished !== exp_fr.finished) begin
          $error("finished expected %0d got %0d", exp_fr.finished, out_if.finished);
          errors++;
        end
      end
    end
  end

  task automatic test_end_of_store;
    send_request(KIND_PULL, 16'h0);
    send_request(KIND_WRITE, 16'd0, 16'h7FFF, 16'h8000);
    send_request(KIND_WRITE, 16'd1, 16'h8000, 16'h7FFF);
    for (int i = 2; i < 64; i++)
      send_request(KIND_WRITE, 16'(i), 16'($urandom), 16'($urandom));
    for (int i = 65528; i < 65536; i++)
      send_request(KIND_WRITE, 16'(i), 16'($urandom), 16'($urandom));
    send_request(KIND_START, 16'd65530);
    repeat (8) send_request(KIND_PULL, 16'h0);
    send_request(KIND_PULL, 16'h0);
    drain();
  endtask

  task automatic test_directed;
    // zero step, mono, full-scale left and zero right volume, one fade each way
    set_voice(10, 0, 65535, 0, 4, 3, 2, 0);
    send_request(KIND_START, 16'hFFFF);
    repeat (3) send_request(KIND_PULL, 16'h0);
    send_request(KIND_STOP, 16'h0);
    send_request(KIND_PULL, 16'h0);
    drain();
    set_voice(12, -1048576, 4096, 65535, 65536, 0, -1, 1);
    send_request(KIND_START, 16'd5);
    repeat (4) send_request(KIND_PULL, 16'h0);
    drain();
    set_voice(3, 1048575, 0, 4096, 0, 65536, 65535, 1);
    send_request(KIND_START, 16'd0);
    repeat (4) send_request(KIND_PULL, 16'h0);
    drain();
    set_voice(20, -2500, 5000, 3000, 6, 6, 3, 1);
    send_request(KIND_START, 16'd2);
    repeat (6) send_request(KIND_PULL, 16'h0);
    drain();
  endtask

  task automatic test_backlog;
    set_voice(30, 3000, 4096, 4096, 0, 0, -1, 1);
    send_request(KIND_START, 16'd1);
    hold_pending = 1'b1;
    repeat (12) send_request(KIND_PULL, 16'h0);
    drain();
  endtask

  function automatic int pick_volume;
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      2: return 4096;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic test_random;
    int cnt, stp, fin, fout, loops, sel;
    logic [15:0] addr;
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph == 3);
      cnt = ($urandom_range(3) == 0) ? 3 : $urandom_range(3, 62);
      case ($urandom_range(5))
        0: stp = -1048576;
        1: stp = 1048575;
        2: stp = 0;
        default: stp = $urandom_range(0, 24000) - 12000;
      endcase
      fin = ($urandom_range(3) == 0) ? 65536 : $urandom_range(0, cnt);
      fout = ($urandom_range(3) == 0) ? 65536 : $urandom_range(0, cnt);
      case ($urandom_range(4))
        0: loops = -1;
        1: loops = 0;
        2: loops = 65535;
        default: loops = $urandom_range(1, 5);
      endcase
      set_voice(cnt, stp, pick_volume(), pick_volume(), fin, fout, loops,
                $urandom_range(1));
      send_request(KIND_START, 16'($urandom_range(cnt)));
      for (int n = 0; n < 118; n++) begin
        sel = $urandom_range(99);
        if (sel < 75) begin
          send_request(KIND_PULL, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (sel < 84) begin
          addr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(cnt));
          send_request(KIND_START, addr, 16'($urandom), 16'($urandom));
        end else if (sel < 88) begin
          send_request(KIND_STOP, 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          addr = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(63));
          send_request(KIND_WRITE, addr, 16'($urandom), 16'($urandom));
        end
      end
      send_request(KIND_STOP, 16'h0);
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_WRITE;
    in_if.sample_address = '0;
    in_if.left_sample = '0;
    in_if.right_sample = '0;
    reg_shadow[REG_SAMPLE_COUNT] = 65536;
    reg_shadow[REG_STEP] = 4096;
    reg_shadow[REG_LEFT_VOLUME] = 4096;
    reg_shadow[REG_RIGHT_VOLUME] = 4096;
    reg_shadow[REG_FADE_IN] = 0;
    reg_shadow[REG_FADE_OUT] = 0;
    reg_shadow[REG_LOOP_COUNT] = 0;
    reg_shadow[REG_STEREO_MODE] = 1;
    voice_pos = 0;
    voice_loops = 0;
    voice_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_end_of_store();
    test_directed();
    test_backlog();
    test_random();
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end
endmodule
